[rtl/hfd_pkg.sv]
// Shared types and constants for the HTTP/3 frame deframer.
package hfd_pkg;

  // Width of the saturating consumed-byte counter.
  localparam int OFFSET_W   = 16;
  localparam int VARINT_W   = 62;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LIMIT_W    = 16;

  // Register index decoded from paddr[2].
  localparam logic REG_BUFFER_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4096;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  localparam logic [1:0] CLS_HEADERS = 2'd0;
  localparam logic [1:0] CLS_DATA    = 2'd1;
  localparam logic [1:0] CLS_OTHER   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_kind;
    logic        frame_first;
    logic        frame_last;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] consumed_length;
  } out_item_t;

endpackage

[rtl/http3_frame_deframer_top.sv]
// Top level of the HTTP/3 frame deframer: ports, configuration register, parser and output stage.
// The block takes one byte of an HTTP/3 message per cycle on the in_ channel and
// returns at most one item per byte on the out_ channel: an item whenever a HEADERS
// or DATA payload byte passes through, and an item on the end-of-message byte that
// carries the status (ok, truncated, limit exceeded) and the consumed byte count.
// Every byte is handled combinationally by the parser between its state
// registers and a two-deep output stage, so one byte is accepted each cycle for as
// long as the output side keeps taking items; in_ready falls only when both output
// slots are full. Items are registered in the output register or skid slot.
// buffer_limit sits at byte address 0 of the APB port (reset 4096); write it
// only while no message is in flight.
module http3_frame_deframer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte stream
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hfd_pkg::in_item_t               in_data,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output hfd_pkg::out_item_t              out_data,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hfd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hfd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hfd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import hfd_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic               accept;
  logic               res_valid;
  out_item_t          res;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BUFFER_LIMIT);
  assign prdata    = (paddr[2] == REG_BUFFER_LIMIT) ? CFG_DATA_W'(limit_r) : '0;

  // Hold the limit until software writes a new one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_write) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  assign accept = in_valid && in_ready;

  hfd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (accept),
    .item         (in_data),
    .buffer_limit (limit_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Result register plus skid slot: advance the byte stream while an item waits.
  hfd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // A full skid slot always sits behind a full output register.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid) else $error("skid slot full with output register empty");

  // Every item carries a payload byte or the end-of-message report.
  a_no_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.payload_valid || out_data.done_res))
    else $error("empty result item");

  // Status only on the end-of-message item.
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> out_data.done_res)
    else $error("status without done");

  // A register write lands in the limit on the next edge.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write |=> (limit_r == $past(pwdata[LIMIT_W-1:0])))
    else $error("buffer_limit write lost");
`endif

endmodule

[rtl/hfd_core.sv]
// Frame parser: varint decode, payload pass-through and limit check per byte.
module hfd_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  hfd_pkg::in_item_t             item,
  input  logic [hfd_pkg::LIMIT_W-1:0]   buffer_limit,
  output logic                          res_valid,
  output hfd_pkg::out_item_t            res
);
  import hfd_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [2:0]            vleft_r, vleft_nxt;
  logic [VARINT_W-1:0]   acc_r, acc_nxt;
  logic [1:0]            class_r, class_nxt;
  logic [VARINT_W-1:0]   remain_r, remain_nxt;
  logic [OFFSET_W-1:0]   offset_r, offset_nxt;
  logic [1:0]            err_r, err_nxt;
  logic                  first_r, first_nxt;

  logic [VARINT_W-1:0]   acc_take;
  logic [2:0]            left_take;
  logic                  vdone;
  logic                  over_limit;
  logic [32:0]           offset_wide;

  function automatic logic [2:0] prefix_left(input logic [1:0] prefix);
    logic [2:0] n;
    case (prefix)
      2'd0:    n = 3'd0;
      2'd1:    n = 3'd1;
      2'd2:    n = 3'd3;
      default: n = 3'd7;
    endcase
    return n;
  endfunction

  // Varint step: a fresh varint takes the length prefix, else shift in a byte.
  always_comb begin
    if (vleft_r == 3'd0) begin
      acc_take  = VARINT_W'(item.in_byte[5:0]);
      left_take = prefix_left(item.in_byte[7:6]);
    end else begin
      acc_take  = {acc_r[VARINT_W-9:0], item.in_byte};
      left_take = vleft_r - 3'd1;
    end
    vdone = (left_take == 3'd0);
  end

  always_comb begin
    phase_nxt  = phase_r;
    vleft_nxt  = vleft_r;
    acc_nxt    = acc_r;
    class_nxt  = class_r;
    remain_nxt = remain_r;
    offset_nxt = offset_r;
    err_nxt    = err_r;
    first_nxt  = first_r;
    res        = '0;
    res_valid  = 1'b0;
    over_limit = 1'b0;
    offset_wide = '0;

    if (item_valid) begin
      if (err_r == ST_OK) begin
        if (offset_r != {OFFSET_W{1'b1}}) offset_nxt = offset_r + OFFSET_W'(1);
        over_limit = 33'(offset_nxt) >= 33'(buffer_limit);
        case (phase_r)
          PH_PAY: begin
            if (class_r != CLS_OTHER) begin
              res.payload_valid = 1'b1;
              res.payload_byte  = item.in_byte;
              res.frame_kind    = (class_r == CLS_DATA);
              res.frame_first   = first_r;
              res.frame_last    = (remain_r == VARINT_W'(1));
            end
            first_nxt  = 1'b0;
            remain_nxt = remain_r - VARINT_W'(1);
            if (remain_r == VARINT_W'(1)) phase_nxt = PH_TYPE;
          end
          PH_LEN: begin
            acc_nxt   = acc_take;
            vleft_nxt = left_take;
            if (vdone) begin
              if (over_limit) begin
                err_nxt = ST_LIMIT;
              end else begin
                remain_nxt = acc_take;
                if (acc_take == '0) begin
                  phase_nxt = PH_TYPE;
                end else begin
                  phase_nxt = PH_PAY;
                  first_nxt = 1'b1;
                end
              end
            end
          end
          default: begin
            phase_nxt = PH_TYPE;
            acc_nxt   = acc_take;
            vleft_nxt = left_take;
            if (vdone) begin
              if (acc_take == VARINT_W'(1))  class_nxt = CLS_HEADERS;
              else if (acc_take == '0)       class_nxt = CLS_DATA;
              else                           class_nxt = CLS_OTHER;
              phase_nxt = PH_LEN;
            end
          end
        endcase
      end

      if (item.end_of_message) begin
        res.done_res = 1'b1;
        res.status   = err_nxt;
        if (err_nxt == ST_OK) begin
          if (phase_nxt != PH_TYPE || vleft_nxt != 3'd0)
            res.status = ST_TRUNCATED;
          else if (33'(offset_nxt) >= 33'(buffer_limit))
            res.status = ST_LIMIT;
        end
        offset_wide = 33'(offset_nxt);
        res.consumed_length = (offset_wide > 33'h0FFFF) ? 16'hFFFF : offset_wide[15:0];
        // Drop all parse state, ready for the next message.
        phase_nxt  = PH_TYPE;
        vleft_nxt  = '0;
        acc_nxt    = '0;
        class_nxt  = '0;
        remain_nxt = '0;
        offset_nxt = '0;
        err_nxt    = ST_OK;
        first_nxt  = 1'b0;
      end
      res_valid = res.payload_valid | item.end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      vleft_r  <= '0;
      acc_r    <= '0;
      class_r  <= '0;
      remain_r <= '0;
      offset_r <= '0;
      err_r    <= ST_OK;
      first_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      vleft_r  <= vleft_nxt;
      acc_r    <= acc_nxt;
      class_r  <= class_nxt;
      remain_r <= remain_nxt;
      offset_r <= offset_nxt;
      err_r    <= err_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

[rtl/hfd_skid.sv]
// Output register with a skid stage so the input side never waits on out_ready directly.
module hfd_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hfd_pkg::out_item_t push_data,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_ready,
  output hfd_pkg::out_item_t out_data
);
  import hfd_pkg::*;

  logic      out_v_r, skid_v_r;
  out_item_t out_d_r, skid_d_r;

  assign ready     = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_ready) begin
      if (push) skid_v_r <= 1'b1;
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_ready) begin
      if (push && !skid_v_r) skid_d_r <= push_data;
    end else if (skid_v_r) begin
      out_d_r <= skid_d_r;
    end else if (push) begin
      out_d_r <= push_data;
    end
  end

endmodule
